// File: rtl/core/cma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int FRAME_W    = 24;
    localparam int TRK_W      = 24;
    localparam int HW_W       = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_HALF_WINDOW = REG_IDX_W'(0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RM_SUB,
        ST_DIV,
        ST_PUT
    } cma_state_t;

endpackage

// File: rtl/core/cma_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_in_if
// Input channel: one trajectory point per item.
// ----------------------------------------------------------------------------
interface cma_in_if
    import cma_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic        [FRAME_W-1:0]    frame_no;
    logic                         end_of_track;

    modport source (
        output valid, pos_x, pos_y, frame_no, end_of_track,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, frame_no, end_of_track,
        output ready
    );
endinterface

// File: rtl/core/cma_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_out_if
// Output channel: one smoothed trajectory point per item.
// ----------------------------------------------------------------------------
interface cma_out_if
    import cma_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] avg_x;
    logic signed [COORD_BITS-1:0] avg_y;
    logic        [FRAME_W-1:0]    out_frame;
    logic                         last_out;

    modport source (
        output valid, avg_x, avg_y, out_frame, last_out,
        input  ready
    );

    modport sink (
        input  valid, avg_x, avg_y, out_frame, last_out,
        output ready
    );
endinterface

// File: rtl/core/cma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_div
// Bit-serial signed divider, one quotient bit per cycle, rounds to nearest
// with ties away from zero.
// ----------------------------------------------------------------------------
module cma_div
    import cma_pkg::*;
#(
    parameter int SUM_W = 30,
    parameter int CNT_W = 7,
    parameter int Q_W   = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] sum,
    input  logic        [CNT_W-1:0] cnt,
    output logic                    busy,
    output logic        [Q_W-1:0]   quot
);

    localparam int DVD_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;
    logic [Q_W-1:0]    q_low;

    always_comb
    begin
        mag   = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, cnt};
        fits  = trial >= {1'b0, cnt};

        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            neg_next  = sum[SUM_W-1];
            dvd_next  = {1'b0, mag} + DVD_W'(cnt >> 1);
            rem_next  = '0;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            busy_next = step_reg != STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign q_low = dvd_reg[Q_W-1:0];
    assign quot  = neg_reg ? (~q_low + Q_W'(1)) : q_low;
    assign busy  = busy_reg;

endmodule

// File: rtl/core/centered_moving_average_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average_2d
// Centered moving average of 2-D trajectory points with clipped edges.
// ----------------------------------------------------------------------------
// The block takes one point at a time and is ready only while idle. An
// input that completes a window spends almost all of its time in the
// bit-serial dividers, one quotient bit per cycle; an input that completes
// no window leaves the block idle. The end-of-track input emits every
// pending point, up to half_window of them, each through the dividers.
// Window sums are kept running: every output after the first half_window
// drops its oldest point with one history read; right after the 24-bit
// point counter wraps, an output drops up to half_window points. A
// finished result sits in an output register, so the next item can enter
// while it waits. A write to half_window discards the trajectory in
// progress.
// ----------------------------------------------------------------------------
module centered_moving_average_2d
    import cma_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 32,
    parameter int COORD_BITS      = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    cma_in_if.sink                in_ch,
    cma_out_if.source             out_ch
);

    localparam int HIST_AW = $clog2(2 * MAX_HALF_WINDOW);
    localparam int HIST_D  = 1 << HIST_AW;
    localparam int CNT_W   = HIST_AW + 1;
    localparam int SUM_W   = COORD_BITS + HIST_AW;
    localparam int MEM_W   = 2 * COORD_BITS + FRAME_W;

    cma_state_t state_reg, state_next;

    logic [HW_W-1:0]         hw_reg, hw_next;
    logic [TRK_W-1:0]        in_seen_reg, in_seen_next;
    logic [TRK_W-1:0]        out_given_reg, out_given_next;
    logic [TRK_W-1:0]        lo_reg, lo_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    flush_reg, flush_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic signed [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [FRAME_W-1:0]           out_frame_reg, out_frame_next;
    logic                         out_last_reg, out_last_next;

    logic                  cfg_wr;
    logic [HW_W-1:0]       hw_clamped;
    logic                  in_fire;
    logic                  out_load;
    logic                  is_last;
    logic [TRK_W-1:0]      gap;
    logic [TRK_W-1:0]      sm1;
    logic [TRK_W-1:0]      lo_target;
    logic                  div_start;
    logic                  x_busy;
    logic                  y_busy;
    logic [COORD_BITS-1:0] x_quot;
    logic [COORD_BITS-1:0] y_quot;

    logic                  ram_we;
    logic [HIST_AW-1:0]    ram_waddr;
    logic [MEM_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [HIST_AW-1:0]    ram_raddr;
    logic [MEM_W-1:0]      ram_rdata;

    logic signed [COORD_BITS-1:0] old_x;
    logic signed [COORD_BITS-1:0] old_y;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_HALF_WINDOW);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_HALF_WINDOW)
                    ? APB_DATA_W'(hw_reg) : '0;

    always_comb
    begin
        priority if (pwdata == '0)
        begin
            hw_clamped = HW_W'(1);
        end
        else if (pwdata > APB_DATA_W'(MAX_HALF_WINDOW))
        begin
            hw_clamped = HW_W'(MAX_HALF_WINDOW);
        end
        else
        begin
            hw_clamped = pwdata[HW_W-1:0];
        end
    end

    assign in_ch.ready = state_reg == ST_IDLE;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign ram_we    = in_fire;
    assign ram_waddr = in_seen_reg[HIST_AW-1:0];
    assign ram_wdata = {in_ch.pos_x, in_ch.pos_y, in_ch.frame_no};
    assign old_x     = ram_rdata[MEM_W-1 -: COORD_BITS];
    assign old_y     = ram_rdata[FRAME_W +: COORD_BITS];

    assign gap       = in_seen_reg - out_given_reg;
    assign sm1       = TRK_W'(hw_reg - HW_W'(1));
    assign lo_target = (out_given_reg >= sm1) ? (out_given_reg - sm1) : '0;
    assign is_last   = flush_reg && ((out_given_reg + TRK_W'(1)) == in_seen_reg);

    always_comb
    begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        in_seen_next   = in_seen_reg;
        out_given_next = out_given_reg;
        lo_next        = lo_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        cnt_next       = cnt_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_frame_next = out_frame_reg;
        out_last_next  = out_last_reg;
        ram_re         = 1'b0;
        ram_raddr      = lo_reg[HIST_AW-1:0];
        div_start      = 1'b0;
        out_load       = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sum_x_next   = sum_x_reg + SUM_W'(in_ch.pos_x);
                    sum_y_next   = sum_y_reg + SUM_W'(in_ch.pos_y);
                    cnt_next     = cnt_reg + CNT_W'(1);
                    in_seen_next = in_seen_reg + TRK_W'(1);
                    flush_next   = in_ch.end_of_track;
                    if (in_ch.end_of_track || (gap >= sm1))
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                ram_re = 1'b1;
                if (lo_reg != lo_target)
                begin
                    state_next = ST_RM_SUB;
                end
                else
                begin
                    // window settled, fetch the center frame and divide
                    ram_raddr  = out_given_reg[HIST_AW-1:0];
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_RM_SUB:
            begin
                sum_x_next = sum_x_reg - SUM_W'(old_x);
                sum_y_next = sum_y_reg - SUM_W'(old_y);
                cnt_next   = cnt_reg - CNT_W'(1);
                lo_next    = lo_reg + TRK_W'(1);
                state_next = ST_CHECK;
            end

            ST_DIV:
            begin
                if (!x_busy)
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_x_next     = x_quot;
                    out_y_next     = y_quot;
                    out_frame_next = ram_rdata[FRAME_W-1:0];
                    out_last_next  = is_last;
                    out_given_next = out_given_reg + TRK_W'(1);
                    if (is_last)
                    begin
                        in_seen_next   = '0;
                        out_given_next = '0;
                        lo_next        = '0;
                        sum_x_next     = '0;
                        sum_y_next     = '0;
                        cnt_next       = '0;
                        flush_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else if (flush_reg)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write drops the trajectory in progress
        if (cfg_wr)
        begin
            hw_next        = hw_clamped;
            in_seen_next   = '0;
            out_given_next = '0;
            lo_next        = '0;
            sum_x_next     = '0;
            sum_y_next     = '0;
            cnt_next       = '0;
            flush_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hw_reg        <= HW_W'(1);
            in_seen_reg   <= '0;
            out_given_reg <= '0;
            lo_reg        <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            in_seen_reg   <= in_seen_next;
            out_given_reg <= out_given_next;
            lo_reg        <= lo_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_frame_reg <= out_frame_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.avg_x     = out_x_reg;
    assign out_ch.avg_y     = out_y_reg;
    assign out_ch.out_frame = out_frame_reg;
    assign out_ch.last_out  = out_last_reg;

    cma_ram #(
        .WIDTH (MEM_W),
        .DEPTH (HIST_D)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W),
        .Q_W   (COORD_BITS)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_x_reg),
        .cnt   (cnt_reg),
        .busy  (x_busy),
        .quot  (x_quot)
    );

    cma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W),
        .Q_W   (COORD_BITS)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_y_reg),
        .cnt   (cnt_reg),
        .busy  (y_busy),
        .quot  (y_quot)
    );

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> cnt_reg != '0)
        else $error("divider started on an empty window");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        x_busy == y_busy)
        else $error("x and y dividers out of step");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (HW_W + 1)'(cnt_reg) <= {hw_reg, 1'b0})
        else $error("window holds too many points");

    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last_next |=> in_seen_reg == '0 && out_given_reg == '0)
        else $error("point counters not cleared after end of track");

endmodule
